// ----- rtl/core/mtsu_pkg.sv -----
// Package for the Metropolis spin site update block.
// Lattice size, field widths, constants and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package mtsu_pkg;

	localparam int SIDE        = 32;
	localparam int NSITES      = SIDE * SIDE * SIDE;
	localparam int ADDR_W      = 15;
	localparam int STORE_DEPTH = 32768;
	localparam int K_W         = $clog2(SIDE);
	localparam int SPIN_W      = 3;
	localparam int FRAC_W      = 16;
	localparam int P_W         = FRAC_W + 1;
	localparam int MAG_W       = 18;
	localparam int EN_W        = 19;
	localparam int DE_W        = 6;
	localparam int CNT_W       = 5;
	localparam int IN_W        = 24;
	localparam int OUT_W       = 56;

	localparam logic [ADDR_W-1:0] LAST_SITE  = ADDR_W'(NSITES - 1);
	localparam logic [K_W-1:0]    LAST_K     = K_W'(SIDE - 1);
	localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(SIDE);
	localparam logic [P_W-1:0]    ONE_Q16    = P_W'(1 << FRAC_W);
	localparam logic signed [SPIN_W-1:0] SPIN_ONE = 3'sd1;
	localparam logic signed [SPIN_W-1:0] SPIN_MAX = 3'sd2;
	localparam logic signed [SPIN_W-1:0] SPIN_MIN = -3'sd2;
	localparam logic [FRAC_W-1:0] W_RESET    = 16'd3;
	localparam logic signed [MAG_W-1:0] MAG_RESET = MAG_W'(NSITES);
	localparam logic signed [EN_W-1:0]  EN_RESET  = EN_W'(NSITES / 2);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_OLD,
		ST_RD_KM,
		ST_RD_KP,
		ST_DE,
		ST_POW,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/core/mtsu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used as the spin store; no package dependency.
`timescale 1ns / 1ps

module mtsu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/metropolis_spin_site_update_top.sv -----
// Top level of the Metropolis spin site update block.
// Depends on mtsu_pkg and mtsu_ram.
`timescale 1ns / 1ps

// One item proposes a spin for the next lattice site in raster order and
// brings a uniform Q0.16 draw. From acceptance to result an item steps
// through the states RD_OLD, RD_KM, RD_KP and DE, then POW when the energy
// change dE is positive (dE is at most 16), and DONE. The input takes no
// new item until the result is placed in the output register. The time per
// item is set by three sequential reads on the one read port of the spin
// store (site, left and right neighbor) and by the one 17x16 multiplier
// that forms w^dE one factor per cycle. The spin store needs no clearing
// pass after reset: during the first sweep every site not yet visited
// reads as spin +1, and each visit writes its site back. A result waiting
// in the output register does not stop the next item from being taken.
module metropolis_spin_site_update_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [2:0] proposed_spin, [18:3] uniform_draw
	input  logic [23:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] accepted, [15:1] site_index, [33:16] magnetization, [52:34] energy
	output logic [55:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	mtsu_pkg::state_t state_q, state_d;

	logic [mtsu_pkg::FRAC_W-1:0]        w_q;
	logic [mtsu_pkg::ADDR_W-1:0]        site_q, row_q;
	logic [mtsu_pkg::K_W-1:0]           k_q;
	logic                               swept_q;
	logic signed [mtsu_pkg::MAG_W-1:0]  mag_q;
	logic signed [mtsu_pkg::EN_W-1:0]   en_q;
	logic signed [mtsu_pkg::SPIN_W-1:0] prop_q, old_q, km_q;
	logic [mtsu_pkg::FRAC_W-1:0]        u_q;
	logic signed [mtsu_pkg::DE_W-1:0]   de_q;
	logic [mtsu_pkg::P_W-1:0]           p_q;
	logic [mtsu_pkg::CNT_W-1:0]         cnt_q;
	logic                               rd_ok_q;

	logic                               out_valid_q;
	logic [mtsu_pkg::OUT_W-1:0]         out_data_q;
	logic                               out_last_q;

	logic                               in_fire, slot_free, done_fire;
	logic [mtsu_pkg::ADDR_W-1:0]        rd_addr;
	logic                               rd_ok_d;
	logic [mtsu_pkg::SPIN_W-1:0]        rd_data;
	logic signed [mtsu_pkg::SPIN_W-1:0] rd_spin;
	logic [mtsu_pkg::K_W-1:0]           km, kp;
	logic signed [mtsu_pkg::SPIN_W-1:0] in_spin, in_sat;
	logic signed [3:0]                  diff, nsum;
	logic signed [7:0]                  prod;
	logic signed [mtsu_pkg::DE_W-1:0]   de_d;
	logic [32:0]                        mult;
	logic                               acc;
	logic signed [mtsu_pkg::SPIN_W-1:0] new_spin;
	logic signed [mtsu_pkg::MAG_W-1:0]  mag_d;
	logic signed [mtsu_pkg::EN_W-1:0]   en_d;

	assign cfg_ready = 1'b1;
	assign in_fire   = s_tvalid && s_tready;
	assign slot_free = !out_valid_q || m_tready;
	assign done_fire = (state_q == mtsu_pkg::ST_DONE) && slot_free;

	// Saturate the proposed spin code to -2..2
	assign in_spin = $signed(s_tdata[2:0]);
	always_comb begin
		if (in_spin > mtsu_pkg::SPIN_MAX) begin
			in_sat = mtsu_pkg::SPIN_MAX;
		end else if (in_spin < mtsu_pkg::SPIN_MIN) begin
			in_sat = mtsu_pkg::SPIN_MIN;
		end else begin
			in_sat = in_spin;
		end
	end

	assign km = (k_q == '0) ? mtsu_pkg::LAST_K : k_q - 1'b1;
	assign kp = (k_q == mtsu_pkg::LAST_K) ? '0 : k_q + 1'b1;

	// Sites never written yet read as +1
	assign rd_spin = rd_ok_q ? $signed(rd_data) : mtsu_pkg::SPIN_ONE;

	assign diff = 4'(prop_q) - 4'(old_q);
	assign nsum = 4'(km_q) + 4'(rd_spin);
	assign prod = 8'(diff) * 8'(nsum);
	assign de_d = -(mtsu_pkg::DE_W'(prod));

	assign mult = 33'(p_q) * 33'(w_q);

	assign acc      = (de_q <= 0) || (p_q > mtsu_pkg::P_W'(u_q));
	assign new_spin = acc ? prop_q : old_q;
	assign mag_d    = acc ? mag_q + mtsu_pkg::MAG_W'(prop_q) - mtsu_pkg::MAG_W'(old_q) : mag_q;
	assign en_d     = acc ? en_q + mtsu_pkg::EN_W'(de_q) : en_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mtsu_pkg::ST_IDLE:   if (in_fire) state_d = mtsu_pkg::ST_RD_OLD;
			mtsu_pkg::ST_RD_OLD: state_d = mtsu_pkg::ST_RD_KM;
			mtsu_pkg::ST_RD_KM:  state_d = mtsu_pkg::ST_RD_KP;
			mtsu_pkg::ST_RD_KP:  state_d = mtsu_pkg::ST_DE;
			mtsu_pkg::ST_DE: begin
				state_d = (de_d > 0) ? mtsu_pkg::ST_POW : mtsu_pkg::ST_DONE;
			end
			mtsu_pkg::ST_POW: begin
				if (cnt_q == mtsu_pkg::CNT_W'(1)) state_d = mtsu_pkg::ST_DONE;
			end
			mtsu_pkg::ST_DONE:   if (slot_free) state_d = mtsu_pkg::ST_IDLE;
			default:             state_d = mtsu_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: input ready and spin store read address
	always_comb begin
		s_tready = 1'b0;
		rd_addr  = site_q;
		case (state_q)
			mtsu_pkg::ST_IDLE:   s_tready = 1'b1;
			mtsu_pkg::ST_RD_OLD: rd_addr  = site_q;
			mtsu_pkg::ST_RD_KM:  rd_addr  = row_q + mtsu_pkg::ADDR_W'(km);
			mtsu_pkg::ST_RD_KP:  rd_addr  = row_q + mtsu_pkg::ADDR_W'(kp);
			default:             rd_addr  = site_q;
		endcase
		rd_ok_d = swept_q || (rd_addr < site_q);
	end

	mtsu_ram #(
		.WIDTH(mtsu_pkg::SPIN_W),
		.DEPTH(mtsu_pkg::STORE_DEPTH)
	) u_spin_store (
		.clk  (clk),
		.we   (done_fire),
		.waddr(site_q),
		.wdata(new_spin),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mtsu_pkg::ST_IDLE;
			w_q         <= mtsu_pkg::W_RESET;
			site_q      <= '0;
			row_q       <= '0;
			k_q         <= '0;
			swept_q     <= 1'b0;
			mag_q       <= mtsu_pkg::MAG_RESET;
			en_q        <= mtsu_pkg::EN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				w_q <= cfg_data;
			end
			if (done_fire) begin
				mag_q <= mag_d;
				en_q  <= en_d;
				// Advance the raster position
				if (site_q == mtsu_pkg::LAST_SITE) begin
					site_q  <= '0;
					row_q   <= '0;
					k_q     <= '0;
					swept_q <= 1'b1;
				end else begin
					site_q <= site_q + 1'b1;
					if (k_q == mtsu_pkg::LAST_K) begin
						k_q   <= '0;
						row_q <= row_q + mtsu_pkg::ROW_STEP;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
			end
			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		rd_ok_q <= rd_ok_d;
		case (state_q)
			mtsu_pkg::ST_IDLE: begin
				if (in_fire) begin
					prop_q <= in_sat;
					u_q    <= s_tdata[18:3];
				end
			end
			mtsu_pkg::ST_RD_KM: old_q <= rd_spin;
			mtsu_pkg::ST_RD_KP: km_q  <= rd_spin;
			mtsu_pkg::ST_DE: begin
				de_q  <= de_d;
				p_q   <= mtsu_pkg::ONE_Q16;
				cnt_q <= mtsu_pkg::CNT_W'(de_d);
			end
			mtsu_pkg::ST_POW: begin
				// One truncated Q1.16 product per cycle
				p_q   <= mult[mtsu_pkg::FRAC_W +: mtsu_pkg::P_W];
				cnt_q <= cnt_q - 1'b1;
			end
			mtsu_pkg::ST_DONE: begin
				if (slot_free) begin
					out_data_q <= {3'b000, en_d, mag_d, site_q, acc};
					out_last_q <= (site_q == mtsu_pkg::LAST_SITE);
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

// ----- rtl/core/mtsu_checker.sv -----
// Port-level assertions for the Metropolis spin site update block.
// Depends on mtsu_pkg; bound to metropolis_spin_site_update_top.
`timescale 1ns / 1ps

module mtsu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic        m_tlast
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// The block works on one item at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after an accepted item");

	// Sweep end marks exactly the last site
	a_last_site: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[15:1] == mtsu_pkg::LAST_SITE)))
		else $error("sweep end does not match site index");

endmodule

bind metropolis_spin_site_update_top mtsu_checker u_mtsu_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the Metropolis spin site update block.
// Drives proposals over the stream input, predicts every site result in
// SystemVerilog and compares it against the stream output. Needs mtsu_pkg.
`timescale 1ns / 1ps

module tb_top;
	import mtsu_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_PRINTED    = 40;

	typedef struct packed {
		logic signed [SPIN_W-1:0] spin;
		logic [FRAC_W-1:0]        draw;
	} proposal_t;

	typedef struct packed {
		logic                     acc;
		logic [ADDR_W-1:0]        site;
		logic signed [MAG_W-1:0]  mag;
		logic signed [EN_W-1:0]   energy;
		logic                     sweep_end;
	} site_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// [2:0] proposed_spin, [18:3] uniform_draw
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [0] accepted, [15:1] site_index, [33:16] magnetization, [52:34] energy
	logic [55:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	// lattice predictor state
	logic signed [SPIN_W-1:0] lattice [STORE_DEPTH];
	logic [ADDR_W-1:0]        visit_site;
	logic signed [MAG_W-1:0]  total_mag;
	logic signed [EN_W-1:0]   total_energy;
	logic [FRAC_W-1:0]        weight;

	proposal_t    proposal_q [$];
	site_result_t predicted_q [$];
	proposal_t    offered;

	int items_queued = 0;
	int items_in = 0;
	int send_gap_pct = 0;
	int sink_stall_pct = 0;
	int mismatches = 0;
	int taken = 0;
	int uphill_taken = 0;
	int sweeps = 0;
	int weight_writes = 0;
	int stall_cycles = 0;

	metropolis_spin_site_update_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Visit the current site, decide the proposal and advance the raster.
	function automatic site_result_t metropolis_step(input proposal_t p);
		int spin_val, old_spin, nbr_sum, de, k, row, kp, km;
		longint unsigned pw;
		site_result_t r;
		spin_val = $signed(p.spin);
		if (spin_val < int'(SPIN_MIN))
			spin_val = SPIN_MIN;
		if (spin_val > int'(SPIN_MAX))
			spin_val = SPIN_MAX;
		k = int'(visit_site) % SIDE;
		row = int'(visit_site) - k;
		kp = (k == SIDE - 1) ? 0 : k + 1;
		km = (k == 0) ? SIDE - 1 : k - 1;
		old_spin = lattice[visit_site];
		nbr_sum = int'(lattice[ADDR_W'(row + km)]) + int'(lattice[ADDR_W'(row + kp)]);
		de = -(spin_val - old_spin) * nbr_sum;
		if (de <= 0) begin
			r.acc = 1'b1;
		end else begin
			pw = ONE_Q16;
			for (int e = 0; e < de; e++)
				pw = (pw * weight) >> FRAC_W;
			r.acc = pw > p.draw;
			if (r.acc)
				uphill_taken++;
		end
		if (r.acc) begin
			lattice[visit_site] = SPIN_W'(spin_val);
			total_mag = MAG_W'(int'(total_mag) + spin_val - old_spin);
			total_energy = EN_W'(int'(total_energy) + de);
		end
		r.site = visit_site;
		r.mag = total_mag;
		r.energy = total_energy;
		r.sweep_end = (visit_site == LAST_SITE);
		visit_site = (visit_site == LAST_SITE) ? '0 : visit_site + 1'b1;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("MISMATCH at %0t ns: %s", $time, msg);
	endtask

	// Driver: offer the next pending item, hold it until taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predicted_q.push_back(metropolis_step(offered));
				items_in++;
			end
			if (!s_tvalid || s_tready) begin
				if (proposal_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					offered = proposal_q.pop_front();
					s_tdata <= {5'b0, offered.draw, offered.spin};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare every taken result against the oldest prediction.
	always @(posedge clk) begin
		site_result_t got;
		site_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.acc = m_tdata[0];
				got.site = m_tdata[15:1];
				got.mag = m_tdata[33:16];
				got.energy = m_tdata[52:34];
				got.sweep_end = m_tlast;
				if (predicted_q.size() == 0) begin
					report_mismatch($sformatf("result for site %0d with no item pending",
						got.site));
				end else begin
					want = predicted_q.pop_front();
					if (want.acc)
						taken++;
					if (want.sweep_end)
						sweeps++;
					if (got.acc !== want.acc)
						report_mismatch($sformatf("site %0d accepted: got %0b, expected %0b",
							want.site, got.acc, want.acc));
					if (got.site !== want.site)
						report_mismatch($sformatf("site index: got %0d, expected %0d",
							got.site, want.site));
					if (got.mag !== want.mag)
						report_mismatch($sformatf("site %0d magnetization: got %0d, expected %0d",
							want.site, got.mag, want.mag));
					if (got.energy !== want.energy)
						report_mismatch($sformatf("site %0d energy: got %0d, expected %0d",
							want.site, got.energy, want.energy));
					if (got.sweep_end !== want.sweep_end)
						report_mismatch($sformatf("site %0d sweep end: got %0b, expected %0b",
							want.site, got.sweep_end, want.sweep_end));
				end
			end
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			(cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("tb_top failed");
				$finish;
			end
		end
	end

	task automatic queue_proposal(input proposal_t p);
		proposal_q.push_back(p);
		items_queued++;
	endtask

	// Hold until every queued item is taken and every result has come back.
	task automatic wait_drained();
		do @(posedge clk);
		while (items_in != items_queued || predicted_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_weight(input logic [FRAC_W-1:0] w);
		cfg_data <= w;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		weight = w;
		weight_writes++;
	endtask

	function automatic proposal_t random_proposal();
		proposal_t p;
		// mostly legal spins, some out-of-range codes
		if ($urandom_range(99) < 12)
			p.spin = SPIN_W'($urandom_range(7));
		else
			p.spin = SPIN_W'(int'($urandom_range(4)) - 2);
		case ($urandom_range(9))
			0: p.draw = '0;
			1: p.draw = '1;
			2, 3: p.draw = FRAC_W'($urandom_range(255));
			default: p.draw = FRAC_W'($urandom_range(65535));
		endcase
		return p;
	endfunction

	task automatic run_random(input int n);
		repeat (n)
			queue_proposal(random_proposal());
		wait_drained();
	endtask

	initial begin
		logic [FRAC_W-1:0] phase_weight [8];
		proposal_t p;

		foreach (lattice[i])
			lattice[i] = SPIN_ONE;
		visit_site = '0;
		total_mag = MAG_RESET;
		total_energy = EN_RESET;
		weight = W_RESET;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every spin code, including the saturating ones, at the reset weight.
		for (int c = -4; c <= 3; c++) begin
			p.spin = SPIN_W'(c);
			p.draw = (c % 2 == 0) ? '0 : '1;
			queue_proposal(p);
		end
		wait_drained();

		// Full weight: uphill moves pass unless the draw is at the top.
		set_weight('1);
		for (int c = -4; c <= 3; c++) begin
			p.spin = SPIN_W'(c);
			p.draw = (c % 2 == 0) ? '1 : '0;
			queue_proposal(p);
		end
		wait_drained();

		// Zero weight: no uphill move may pass even with a zero draw.
		set_weight('0);
		for (int c = -4; c <= 3; c++) begin
			p.spin = SPIN_W'(c);
			p.draw = '0;
			queue_proposal(p);
		end
		wait_drained();

		phase_weight = '{16'd0, 16'hFFFF, 16'd40000, 16'd0, 16'd1, 16'd62000, 16'hFFFE, 16'd0};
		phase_weight[3] = FRAC_W'($urandom_range(65535));
		phase_weight[7] = FRAC_W'($urandom_range(32768, 65535));
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_gap_pct = 0; sink_stall_pct = 0; end
				1: begin send_gap_pct = 60; sink_stall_pct = 0; end
				2: begin send_gap_pct = 0; sink_stall_pct = 60; end
				default: begin send_gap_pct = 22; sink_stall_pct = 22; end
			endcase
			set_weight(phase_weight[ph]);
			// sender pauses for a full drain between the two halves
			run_random(105);
			run_random(105);
		end

		// Close with a short run at full rate under a fresh weight.
		send_gap_pct = 0;
		sink_stall_pct = 0;
		set_weight(FRAC_W'($urandom_range(30000, 65535)));
		run_random(40);

		repeat (40) @(posedge clk);
		$display("Ran %0d proposals under %0d weight settings and four pacing modes.",
			items_in, weight_writes);
		$display("%0d proposals taken (%0d uphill), %0d complete sweeps.",
			taken, uphill_taken, sweeps);
		if (mismatches == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
